// File: rtl/irdc_pkg.sv
package irdc_pkg;

  localparam int ADC_W  = 12;
  localparam int DIST_W = 7;
  localparam int SNS_W  = 2;
  localparam int PT_W   = 4;

  localparam logic OP_CONVERT = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  localparam logic [DIST_W-1:0] DIST_NEAR = 7'd10;
  localparam logic [DIST_W-1:0] DIST_FAR  = 7'd80;
  localparam int DIST_STEP = 5;

  // fraction numerator 5*(hi-adc) fits 15 bits
  localparam int NUM_W  = ADC_W + 3;
  localparam int FRAC_W = 3;

  // scan outcome carried into the divider
  typedef struct packed {
    logic              near;
    logic              far;
    logic [NUM_W-1:0]  num;
    logic [ADC_W-1:0]  den;
    logic [9:0]        base;
    logic [SNS_W-1:0]  sensor;
  } scan_t;

endpackage

// File: rtl/irdc_div.sv
module irdc_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_valid,
  input  irdc_pkg::scan_t              in_scan,
  output logic                         out_valid,
  output logic [irdc_pkg::DIST_W-1:0]  out_dist,
  output logic [irdc_pkg::SNS_W-1:0]   out_sensor
);

  // quotient is at most 4, so three restoring steps, one per stage
  localparam int NS = irdc_pkg::FRAC_W;
  localparam int NW = irdc_pkg::NUM_W;
  localparam int DW = irdc_pkg::ADC_W;

  logic            v    [NS];
  irdc_pkg::scan_t s    [NS];
  logic [NW-1:0]   rem  [NS];
  logic [NS-1:0]   quo  [NS];

  logic [NW-1:0]   rem_in  [NS];
  logic [NS-1:0]   quo_in  [NS];
  logic [NW+NS-1:0] dsh    [NS];
  logic [NW-1:0]   rem_nx  [NS];
  logic [NS-1:0]   quo_nx  [NS];

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      rem_in[i] = (i == 0) ? in_scan.num : rem[(i == 0) ? 0 : i-1];
      quo_in[i] = (i == 0) ? '0 : quo[(i == 0) ? 0 : i-1];
      dsh[i]    = {{(NW+NS-DW){1'b0}}, ((i == 0) ? in_scan.den : s[(i == 0) ? 0 : i-1].den)}
                  << (NS-1-i);
      if ({{NS{1'b0}}, rem_in[i]} >= dsh[i]) begin
        rem_nx[i] = NW'({{NS{1'b0}}, rem_in[i]} - dsh[i]);
        quo_nx[i] = quo_in[i] | NS'(1 << (NS-1-i));
      end else begin
        rem_nx[i] = rem_in[i];
        quo_nx[i] = quo_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NS; i++) v[i] <= 1'b0;
    end else if (en) begin
      for (int i = 0; i < NS; i++) v[i] <= (i == 0) ? in_valid : v[(i == 0) ? 0 : i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NS; i++) begin
        s[i]   <= (i == 0) ? in_scan : s[(i == 0) ? 0 : i-1];
        rem[i] <= rem_nx[i];
        quo[i] <= quo_nx[i];
      end
    end
  end

  logic [10:0] sum;
  assign sum       = {1'b0, s[NS-1].base} + 11'(quo[NS-1]);
  assign out_valid = v[NS-1];
  assign out_sensor = s[NS-1].sensor;
  always_comb begin
    if (s[NS-1].near)                          out_dist = irdc_pkg::DIST_NEAR;
    else if (s[NS-1].far)                      out_dist = irdc_pkg::DIST_FAR;
    else if (sum > 11'(irdc_pkg::DIST_FAR))    out_dist = irdc_pkg::DIST_FAR;
    else                                       out_dist = sum[irdc_pkg::DIST_W-1:0];
  end

endmodule

// File: rtl/ir_adc_to_distance_calibration_core.sv
// infrared adc to distance converter for several sensors
// input channel: valid/ready with operation, sensor, point, value
//   operation load writes one threshold of a sensor's table, no result
//   operation convert gives one result: distance_cm and sensor_echo
// thresholds live in one small bank per point, indexed by sensor, so a whole row
//   is read in parallel
// pipeline: stage 1 registers the item and the sensor's row,
//   stage 2 does all threshold compares and picks the bracketing pair,
//   stage 3 forms numerator and denominator, then three restoring
//   divider stages, then the output register
// throughput: one item per cycle while the output is not stalled, a load may follow a convert at once
// the whole pipeline advances only when the output register is free or taken;
//   a stall freezes every stage, nothing is lost or repeated
// reset clears valid bits only; table entries are undefined until loaded
module ir_adc_to_distance_calibration_core #(
  parameter int SENSOR_COUNT = 4,
  parameter int POINT_COUNT  = 15
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         valid,
  output logic                         ready,
  input  logic                         operation,
  input  logic [irdc_pkg::SNS_W-1:0]   sensor,
  input  logic [irdc_pkg::PT_W-1:0]    point,
  input  logic [irdc_pkg::ADC_W-1:0]   value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [irdc_pkg::DIST_W-1:0]  distance_cm,
  output logic [irdc_pkg::SNS_W-1:0]   sensor_echo
);

  localparam int AW = irdc_pkg::ADC_W;
  localparam int SW = irdc_pkg::SNS_W;
  localparam int PS = (POINT_COUNT > 16) ? 16 : POINT_COUNT;
  localparam int KW = $clog2(POINT_COUNT);

  logic en;
  assign en    = !out_valid || out_ready;
  assign ready = en;

  logic [AW-1:0] row_rd [POINT_COUNT];

  for (genvar gp = 0; gp < POINT_COUNT; gp++) begin : g_bank
    if (gp < PS) begin : g_wr
      logic [AW-1:0] bank [SENSOR_COUNT];

      always_ff @(posedge clk) begin
        if (valid && ready && operation == irdc_pkg::OP_LOAD && 32'(point) == gp) begin
          for (int si = 0; si < SENSOR_COUNT; si++)
            if (32'(sensor) == si) bank[si] <= value;
        end
      end

      always_comb begin
        row_rd[gp] = '0;
        for (int si = 0; si < SENSOR_COUNT; si++)
          if (32'(sensor) == si) row_rd[gp] = bank[si];
      end
    end else begin : g_none
      assign row_rd[gp] = '0;
    end
  end

  // stage 1
  logic          v1;
  logic          bad1;
  logic [AW-1:0] adc1;
  logic [SW-1:0] sns1;
  logic [AW-1:0] row1 [POINT_COUNT];

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= valid && operation == irdc_pkg::OP_CONVERT;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      adc1 <= value;
      sns1 <= sensor;
      bad1 <= 32'(sensor) >= SENSOR_COUNT;
      for (int pi = 0; pi < POINT_COUNT; pi++) row1[pi] <= row_rd[pi];
    end
  end

  // stage 2: parallel compares, first deciding point
  logic [POINT_COUNT-1:0] gt;
  always_comb
    for (int pi = 0; pi < POINT_COUNT; pi++) gt[pi] = adc1 > row1[pi];

  logic          v2, near2, far2;
  logic [KW-1:0] k2;
  logic [AW-1:0] hi2, lo2, adc2;
  logic [SW-1:0] sns2;

  logic          near_c, far_c, hit;
  logic [KW-1:0] k_c;
  always_comb begin
    hit = 1'b0; near_c = 1'b0; k_c = '0;
    for (int kk = POINT_COUNT-2; kk >= 0; kk--) begin
      if (gt[kk] || gt[kk+1]) begin
        hit = 1'b1; k_c = KW'(kk); near_c = gt[kk];
      end
    end
    far_c = bad1 || !hit;
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      near2 <= near_c && !bad1;
      far2  <= far_c;
      k2    <= k_c;
      hi2   <= row1[k_c];
      lo2   <= row1[k_c + KW'(1)];
      adc2  <= adc1;
      sns2  <= sns1;
    end
  end

  // stage 3: numerator, denominator, base distance
  logic            v3;
  irdc_pkg::scan_t sc3;
  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  logic [AW-1:0] diff;
  assign diff = hi2 - adc2;

  always_ff @(posedge clk) begin
    if (en) begin
      sc3.near   <= near2;
      sc3.far    <= far2;
      sc3.num    <= {diff, 2'b00} + {2'b00, diff} + 15'd0;
      sc3.den    <= hi2 - lo2;
      sc3.base   <= 10'(irdc_pkg::DIST_NEAR) + 10'(k2) * 10'(irdc_pkg::DIST_STEP);
      sc3.sensor <= sns2;
    end
  end

  logic                        dv;
  logic [irdc_pkg::DIST_W-1:0] dd;
  logic [SW-1:0]               ds;

  irdc_div u_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(v3), .in_scan(sc3),
    .out_valid(dv), .out_dist(dd), .out_sensor(ds)
  );

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= dv;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      distance_cm <= dd;
      sensor_echo <= ds;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance_cm) && $stable(sensor_echo))
    else $error("result changed under stall");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> distance_cm >= irdc_pkg::DIST_NEAR && distance_cm <= irdc_pkg::DIST_FAR)
    else $error("distance out of range");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> ready)
    else $error("pipeline stalled with empty output");

endmodule

// File: tb/sv/irdc_checker.sv
module irdc_checker
  import irdc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              valid,
  input  logic              ready,
  input  logic              operation,
  input  logic [SNS_W-1:0]  sensor,
  input  logic [PT_W-1:0]   point,
  input  logic [ADC_W-1:0]  value,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [DIST_W-1:0] distance_cm,
  input  logic [SNS_W-1:0]  sensor_echo,
  output int                errors,
  output int                pending,
  output int                distances_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SENSORS = 4;
  localparam int POINTS  = 15;

  typedef struct packed {
    logic [DIST_W-1:0] cm;
    logic [SNS_W-1:0]  sns;
  } reading_t;

  logic [ADC_W-1:0] thresholds [SENSORS][POINTS];
  reading_t         expected_readings [$];

  function automatic logic [DIST_W-1:0] distance_for(int s, int adc);
    int hi;
    int lo;
    int d;
    for (int k = 0; k + 1 < POINTS; k++) begin
      hi = thresholds[s][k];
      lo = thresholds[s][k+1];
      if (adc > hi) return DIST_NEAR;
      if (adc > lo) begin
        d = DIST_NEAR + DIST_STEP * k + (DIST_STEP * (hi - adc)) / (hi - lo);
        return (d > DIST_FAR) ? DIST_FAR : DIST_W'(d);
      end
    end
    return DIST_FAR;
  endfunction

  // inputs only move at the rising edge, so the falling edge sees what gets taken
  always @(negedge clk) begin
    reading_t got;
    reading_t want;
    if (rst) begin
      errors = 0;
      pending = 0;
      distances_seen = 0;
    end else begin
      if (valid && ready) begin
        if (operation == OP_LOAD) begin
          if (point < POINTS) thresholds[sensor][point] = value;
        end else begin
          want.cm = distance_for(sensor, value);
          want.sns = sensor;
          expected_readings.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        got.cm = distance_cm;
        got.sns = sensor_echo;
        distances_seen++;
        if (expected_readings.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: distance %0d sensor %0d", got.cm, got.sns);
        end else begin
          want = expected_readings.pop_front();
          if (got.cm !== want.cm || got.sns !== want.sns) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: distance exp %0d got %0d, sensor exp %0d got %0d",
                       want.cm, got.cm, want.sns, got.sns);
          end
        end
      end
      pending = expected_readings.size();
    end
  end

endmodule

// File: tb/sv/testbench.sv
module testbench;
  import irdc_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;

  logic              clk;
  logic              rst;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [SNS_W-1:0]  sensor;
  logic [PT_W-1:0]   point;
  logic [ADC_W-1:0]  value;
  logic              out_valid;
  logic              out_ready;
  logic [DIST_W-1:0] distance_cm;
  logic [SNS_W-1:0]  sensor_echo;
  int                errors;
  int                pending;
  int                distances_seen;
  int                cycles;
  int                loads_sent;
  int                converts_sent;
  bit                calm;
  logic [ADC_W-1:0]  table_copy [4][15];

  ir_adc_to_distance_calibration_core uut (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready),
    .operation(operation), .sensor(sensor), .point(point), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .distance_cm(distance_cm), .sensor_echo(sensor_echo)
  );

  irdc_checker checker_i (
    .clk(clk), .rst(rst), .valid(valid), .ready(ready),
    .operation(operation), .sensor(sensor), .point(point), .value(value),
    .out_valid(out_valid), .out_ready(out_ready),
    .distance_cm(distance_cm), .sensor_echo(sensor_echo),
    .errors(errors), .pending(pending), .distances_seen(distances_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
        $display("timeout after %0d cycles", cycles);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ready <= calm || ($urandom_range(99) >= 11);
    end
  end

  task automatic send(logic op, int s, int p, int v);
    if (!calm) begin
      while ($urandom_range(99) < 11) begin
        valid <= 1'b0;
        @(posedge clk);
      end
    end
    valid <= 1'b1;
    operation <= op;
    sensor <= SNS_W'(s);
    point <= PT_W'(p);
    value <= ADC_W'(v);
    forever begin
      @(negedge clk);
      if (ready) break;
    end
    @(posedge clk);
    if (op == OP_LOAD) begin
      loads_sent++;
      if (p < 15) table_copy[s][p] = ADC_W'(v);
    end else begin
      converts_sent++;
    end
  endtask

  // descending table with random steps, flat steps allowed
  task automatic load_falling_table(int s);
    int level;
    level = $urandom_range(4095, 2000);
    for (int p = 0; p < 15; p++) begin
      send(OP_LOAD, s, p, level);
      level = level - $urandom_range(300, 0);
      if (level < 0) level = 0;
    end
  endtask

  initial begin
    int s;
    int p;
    int t;
    rst = 1'b1;
    valid = 1'b0;
    operation = OP_CONVERT;
    sensor = '0;
    point = '0;
    value = '0;
    calm = 1'b0;
    loads_sent = 0;
    converts_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // every table written before any convert reads it
    for (s = 0; s < 4; s++) begin
      for (p = 0; p < 15; p++)
        send(OP_LOAD, s, p, (s == 3) ? ((p == 0) ? 4095 : 0) : 3800 - 250 * p);
    end

    // directed: extremes, exact thresholds, ignored point, flat step
    send(OP_LOAD, 2, 15, 0);
    send(OP_CONVERT, 0, 15, 4095);
    send(OP_CONVERT, 0, 0, 0);
    send(OP_CONVERT, 0, 0, 3800);
    send(OP_CONVERT, 0, 0, 3801);
    send(OP_CONVERT, 1, 0, 3550);
    send(OP_CONVERT, 1, 0, 3549);
    send(OP_CONVERT, 1, 0, 300);
    send(OP_CONVERT, 1, 0, 301);
    send(OP_CONVERT, 2, 9, 3000);
    send(OP_CONVERT, 3, 0, 4095);
    send(OP_CONVERT, 3, 0, 1);
    send(OP_CONVERT, 3, 0, 0);
    send(OP_LOAD, 1, 5, 2550);
    send(OP_CONVERT, 1, 0, 2550);
    send(OP_CONVERT, 1, 0, 2551);
    send(OP_LOAD, 0, 0, 4095);
    send(OP_CONVERT, 0, 0, 4095);
    send(OP_CONVERT, 2, 0, 2000);

    for (int i = 0; i < 430; i++) begin
      calm = (i >= 180 && i < 280);
      s = $urandom_range(3);
      t = $urandom_range(99);
      if (t < 4) begin
        load_falling_table(s);
      end else if (t < 10) begin
        send(OP_LOAD, s, $urandom_range(15), $urandom_range(4095));
      end else if (t < 55) begin
        p = $urandom_range(14);
        send(OP_CONVERT, s, $urandom_range(15),
             int'(table_copy[s][p]) + $urandom_range(4) - 2 < 0 ? 0 :
             (int'(table_copy[s][p]) + $urandom_range(4) - 2 > 4095 ? 4095 :
              int'(table_copy[s][p]) + $urandom_range(4) - 2));
      end else begin
        send(OP_CONVERT, s, $urandom_range(15), $urandom_range(4095));
      end
    end
    calm = 1'b0;
    valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("sent %0d loads and %0d converts, %0d distances checked",
             loads_sent, converts_sent, distances_seen);
    if (errors == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending);
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
